FILE: rtl/core/url_form_decoder_assert.svh
// Assertion macros shared by the URL form decoder modules.
// Expects signals named clk and rst_n in the including module.
`ifndef URL_FORM_DECODER_ASSERT_SVH
`define URL_FORM_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define UFD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define UFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ufd_pkg.sv
// Package for the URL form decoder: types, constants and the hex mapping.
// No dependencies.
package ufd_pkg;

    localparam int unsigned FIFO_DEPTH = 4;

    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;
    localparam logic [7:0] HEX_TEN      = 8'd10;

    typedef enum logic [1:0] {
        PHASE_PLAIN,
        PHASE_HIGH,
        PHASE_LOW
    } phase_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } result_t;

    // Results caused by one item, in delivery order
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } decode_out_t;

    // Upper-case a letter, then digit or letter offset, 8-bit wraparound
    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
        begin
            u = c - CASE_OFFSET;
        end
        if (u >= CHAR_ZERO && u <= CHAR_NINE)
        begin
            return u - CHAR_ZERO;
        end
        return u - CHAR_UPPER_A + HEX_TEN;
    endfunction

endpackage

FILE: rtl/core/ufd_src_if.sv
// Source-byte channel: valid/ready handshake with one character per item.
// Depends on nothing.
interface ufd_src_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_char;
    logic       src_last;

    modport source (output valid, output src_char, output src_last, input ready);
    modport sink   (input valid, input src_char, input src_last, output ready);
endinterface

FILE: rtl/core/ufd_out_if.sv
// Decoded-byte channel: valid/ready handshake with one byte per item.
// Depends on nothing.
interface ufd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: rtl/core/ufd_decode.sv
// Escape state machine and per-character decode of the URL form decoder.
// Depends on ufd_pkg and url_form_decoder_assert.svh.
`include "url_form_decoder_assert.svh"

module ufd_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          item_char,
    input  logic                item_last,
    output ufd_pkg::decode_out_t dec
);

    ufd_pkg::phase_t phase_reg, phase_next;
    logic [3:0]      high_reg, high_next;
    logic [7:0]      hex_val;

    assign hex_val = ufd_pkg::hex_value(item_char);

    // Next state of the escape machine
    always_comb
    begin
        phase_next = phase_reg;
        high_next  = high_reg;
        unique case (phase_reg)
            ufd_pkg::PHASE_HIGH:
            begin
                high_next  = hex_val[3:0];
                phase_next = ufd_pkg::PHASE_LOW;
            end
            ufd_pkg::PHASE_LOW:
            begin
                phase_next = ufd_pkg::PHASE_PLAIN;
            end
            default:
            begin
                if (item_char == ufd_pkg::CHAR_PERCENT)
                begin
                    phase_next = ufd_pkg::PHASE_HIGH;
                end
                else
                begin
                    phase_next = ufd_pkg::PHASE_PLAIN;
                end
            end
        endcase
        // end of string returns to the start state
        if (item_last)
        begin
            phase_next = ufd_pkg::PHASE_PLAIN;
            high_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ufd_pkg::PHASE_PLAIN;
            high_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            high_reg  <= high_next;
        end
    end

    // Results of the current item
    always_comb
    begin
        logic       have;
        logic [7:0] data;
        have = 1'b0;
        data = '0;
        unique case (phase_reg)
            ufd_pkg::PHASE_HIGH:
            begin
                have = 1'b0;
            end
            ufd_pkg::PHASE_LOW:
            begin
                have = 1'b1;
                data = {high_reg, 4'h0} + hex_val;
            end
            default:
            begin
                if (item_char == ufd_pkg::CHAR_PERCENT)
                begin
                    have = 1'b0;
                end
                else if (item_char == ufd_pkg::CHAR_PLUS)
                begin
                    have = 1'b1;
                    data = ufd_pkg::CHAR_SPACE;
                end
                else
                begin
                    have = 1'b1;
                    data = item_char;
                end
            end
        endcase

        dec.second = '{out_byte: 8'h00, out_last: 1'b1};
        if (have)
        begin
            dec.first = '{out_byte: data, out_last: 1'b0};
            dec.count = item_last ? 2'd2 : 2'd1;
        end
        else
        begin
            dec.first = '{out_byte: 8'h00, out_last: 1'b1};
            dec.count = item_last ? 2'd1 : 2'd0;
        end
    end

    `UFD_ASSERT_NEXT(a_last_resets_state, fire && item_last,
        phase_reg == ufd_pkg::PHASE_PLAIN && high_reg == 4'h0,
        "state not cleared after last character")
    `UFD_ASSERT_NEXT(a_high_then_low, fire && !item_last && phase_reg == ufd_pkg::PHASE_HIGH,
        phase_reg == ufd_pkg::PHASE_LOW, "escape did not move to low nibble")
    `UFD_ASSERT_IMPL(a_last_yields_result, fire && item_last, dec.count != 2'd0,
        "last character produced no terminator")

endmodule

FILE: rtl/core/ufd_result_fifo.sv
// Small result queue: takes up to two results per cycle, delivers one.
// Depends on ufd_pkg, ufd_out_if and url_form_decoder_assert.svh.
`include "url_form_decoder_assert.svh"

module ufd_result_fifo #(
    parameter int unsigned DEPTH = ufd_pkg::FIFO_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    push_n,
    input  ufd_pkg::result_t              push_first,
    input  ufd_pkg::result_t              push_second,
    output logic [$clog2(DEPTH + 1)-1:0]  free_slots,
    ufd_out_if.source                     dst
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    ufd_pkg::result_t fifo_mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_plus1;
    logic             pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_MAX) ? '0 : p + 1'b1;
    endfunction

    assign wr_ptr_plus1 = ptr_inc(wr_ptr_reg);
    assign pop          = dst.valid && dst.ready;
    assign free_slots   = CNT_MAX - count_reg;

    // Output side
    assign dst.valid    = (count_reg != '0);
    assign dst.out_byte = fifo_mem_reg[rd_ptr_reg].out_byte;
    assign dst.out_last = fifo_mem_reg[rd_ptr_reg].out_last;

    // Pointer and fill updates
    always_comb
    begin
        unique case (push_n)
            2'd1:    wr_ptr_next = wr_ptr_plus1;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_plus1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            fifo_mem_reg[wr_ptr_reg] <= push_first;
        end
        if (push_n == 2'd2)
        begin
            fifo_mem_reg[wr_ptr_plus1] <= push_second;
        end
    end

    `UFD_ASSERT_IMPL(a_no_overflow, push_n != 2'd0, CNT_W'(push_n) <= free_slots,
        "result queue overflow")
    `UFD_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_MAX,
        "result count beyond depth")
    `UFD_ASSERT_NEXT(a_count_track, 1'b1,
        count_reg == $past(count_reg) + CNT_W'($past(push_n)) - CNT_W'($past(pop)),
        "result count out of step")

endmodule

FILE: rtl/core/url_form_decoder.sv
// URL form decoder, top level: input register, decode, result queue.
// An accepted character waits in the input register, its bytes in the queue.
// Throughput: one character per cycle; a last character with a byte gives two
// results, sent one per ready cycle; input stalls while the queue lacks room.
// Reset (rst_n, async, active low) clears escape state, handshakes and queue.
// Depends on ufd_pkg, ufd_src_if, ufd_out_if, ufd_decode, ufd_result_fifo.
module url_form_decoder #(
    parameter int unsigned FIFO_DEPTH = ufd_pkg::FIFO_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    ufd_src_if.sink   src,
    ufd_out_if.source dst
);

    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

    logic                 in_valid_reg;
    logic [7:0]           in_char_reg;
    logic                 in_last_reg;
    logic                 fire;
    logic [1:0]           push_n;
    logic [CNT_W-1:0]     free_slots;
    ufd_pkg::decode_out_t dec;

    // Item leaves the input register once its results fit in the queue
    assign fire      = in_valid_reg && (CNT_W'(dec.count) <= free_slots);
    assign push_n    = fire ? dec.count : 2'd0;
    assign src.ready = !in_valid_reg || fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (src.ready)
        begin
            in_valid_reg <= src.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src.ready && src.valid)
        begin
            in_char_reg <= src.src_char;
            in_last_reg <= src.src_last;
        end
    end

    ufd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item_char (in_char_reg),
        .item_last (in_last_reg),
        .dec       (dec)
    );

    ufd_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_result_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_n      (push_n),
        .push_first  (dec.first),
        .push_second (dec.second),
        .free_slots  (free_slots),
        .dst         (dst)
    );

endmodule

FILE: tb/url_form_decoder_tb.sv
// Self-checking testbench for url_form_decoder: directed rows, then random strings.
// Depends on ufd_pkg, ufd_src_if, ufd_out_if and the url_form_decoder RTL.
// Bursty source, patterned sink stalls, behavioural decoder as predictor.
module url_form_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1900;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    // One source character with an optional typed-in expectation
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       typed;
        logic       has_byte;
        logic [7:0] exp_byte;
    } src_row_t;

    localparam int DIRECTED_COUNT = 24;

    // Directed rows: ch, last, typed, has_byte, exp_byte
    localparam src_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{"A",                   1'b0, 1'b1, 1'b1, "A"},
        '{ufd_pkg::CHAR_PLUS,    1'b0, 1'b1, 1'b1, ufd_pkg::CHAR_SPACE},
        '{8'h00,                 1'b0, 1'b1, 1'b1, 8'h00},
        '{8'hFF,                 1'b0, 1'b1, 1'b1, 8'hFF},
        // plain upper-case escape
        '{ufd_pkg::CHAR_PERCENT, 1'b0, 1'b1, 1'b0, 8'h00},
        '{"4",                   1'b0, 1'b1, 1'b0, 8'h00},
        '{"1",                   1'b0, 1'b1, 1'b1, "A"},
        // mixed-case escape, top value
        '{ufd_pkg::CHAR_PERCENT, 1'b0, 1'b1, 1'b0, 8'h00},
        '{"f",                   1'b0, 1'b1, 1'b0, 8'h00},
        '{"F",                   1'b0, 1'b1, 1'b1, 8'hFF},
        // plus and percent taken as hex characters inside an escape
        '{ufd_pkg::CHAR_PERCENT, 1'b0, 1'b1, 1'b0, 8'h00},
        '{ufd_pkg::CHAR_PLUS,    1'b0, 1'b0, 1'b0, 8'h00},
        '{ufd_pkg::CHAR_PERCENT, 1'b0, 1'b0, 1'b0, 8'h00},
        // non-hex characters still map through the arithmetic
        '{ufd_pkg::CHAR_PERCENT, 1'b0, 1'b1, 1'b0, 8'h00},
        '{"z",                   1'b0, 1'b0, 1'b0, 8'h00},
        '{8'h00,                 1'b0, 1'b0, 1'b0, 8'h00},
        // last byte: decoded byte first, terminator second
        '{"x",                   1'b1, 1'b1, 1'b1, "x"},
        // escape cut off right after the percent
        '{ufd_pkg::CHAR_PERCENT, 1'b1, 1'b1, 1'b0, 8'h00},
        // escape cut off after the first hex character
        '{ufd_pkg::CHAR_PERCENT, 1'b0, 1'b1, 1'b0, 8'h00},
        '{"a",                   1'b1, 1'b1, 1'b0, 8'h00},
        // escape completed by the last byte
        '{ufd_pkg::CHAR_PERCENT, 1'b0, 1'b1, 1'b0, 8'h00},
        '{"0",                   1'b0, 1'b1, 1'b0, 8'h00},
        '{"0",                   1'b1, 1'b1, 1'b1, 8'h00},
        '{ufd_pkg::CHAR_PLUS,    1'b1, 1'b1, 1'b1, ufd_pkg::CHAR_SPACE}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Driven values, known from time zero
    logic       src_valid = 1'b0;
    logic [7:0] src_char  = 8'h00;
    logic       src_last  = 1'b0;
    logic       dst_ready = 1'b0;

    ufd_src_if src_ch ();
    ufd_out_if dst_ch ();

    assign src_ch.valid    = src_valid;
    assign src_ch.src_char = src_char;
    assign src_ch.src_last = src_last;
    assign dst_ch.ready    = dst_ready;

    url_form_decoder uut (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src_ch),
        .dst   (dst_ch)
    );

    // Predictor state
    ufd_pkg::phase_t esc_phase = ufd_pkg::PHASE_PLAIN;
    logic [3:0]      hi_nibble = 4'h0;

    src_row_t         source_chars [$];
    ufd_pkg::result_t pending_bytes [$];
    ufd_pkg::result_t want;

    int error_count    = 0;
    int accepted_count = 0;
    int checked_count  = 0;
    int string_count   = 0;
    int cycle_count    = 0;
    int burst_left     = 1;
    int gap_left       = 0;
    logic [7:0] stall_bits = 8'hFF;
    logic [2:0] stall_step = 3'd0;

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    task automatic flag_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        error_count++;
    endtask

    // Hex character to value: fold lower case, then digit or letter offset
    function automatic logic [7:0] hex_digit_value(input logic [7:0] c);
        logic [7:0] u;
        u = (c >= ufd_pkg::CHAR_LOWER_A && c <= ufd_pkg::CHAR_LOWER_Z)
            ? c - ufd_pkg::CASE_OFFSET : c;
        if (u >= ufd_pkg::CHAR_ZERO && u <= ufd_pkg::CHAR_NINE)
        begin
            return u - ufd_pkg::CHAR_ZERO;
        end
        return u - ufd_pkg::CHAR_UPPER_A + ufd_pkg::HEX_TEN;
    endfunction

    // Advance the decoder state on one accepted character, queue its results
    task automatic decode_char(input src_row_t it);
        logic       got;
        logic [7:0] val;
        logic [7:0] nib;
        got = 1'b0;
        val = 8'h00;
        nib = hex_digit_value(it.ch);
        case (esc_phase)
            ufd_pkg::PHASE_HIGH:
            begin
                hi_nibble = nib[3:0];
                esc_phase = ufd_pkg::PHASE_LOW;
            end
            ufd_pkg::PHASE_LOW:
            begin
                val       = {hi_nibble, 4'h0} + nib;
                got       = 1'b1;
                esc_phase = ufd_pkg::PHASE_PLAIN;
            end
            default:
            begin
                if (it.ch == ufd_pkg::CHAR_PERCENT)
                begin
                    esc_phase = ufd_pkg::PHASE_HIGH;
                end
                else if (it.ch == ufd_pkg::CHAR_PLUS)
                begin
                    val = ufd_pkg::CHAR_SPACE;
                    got = 1'b1;
                end
                else
                begin
                    val = it.ch;
                    got = 1'b1;
                end
            end
        endcase
        // typed-in rows override the computed byte
        if (it.typed)
        begin
            got = it.has_byte;
            val = it.exp_byte;
        end
        if (got)
        begin
            pending_bytes.push_back('{out_byte: val, out_last: 1'b0});
        end
        if (it.last)
        begin
            pending_bytes.push_back('{out_byte: 8'h00, out_last: 1'b1});
            esc_phase = ufd_pkg::PHASE_PLAIN;
            hi_nibble = 4'h0;
        end
    endtask

    function automatic void queue_char(input logic [7:0] c);
        source_chars.push_back('{ch: c, last: 1'b0, typed: 1'b0, has_byte: 1'b0,
                                 exp_byte: 8'h00});
    endfunction

    // Random hex digit in either case
    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
        begin
            return ufd_pkg::CHAR_ZERO + 8'(v);
        end
        return ($urandom_range(0, 1) ? ufd_pkg::CHAR_UPPER_A : ufd_pkg::CHAR_LOWER_A)
               + 8'(v - 10);
    endfunction

    // Source side: bursts of random length, random gaps, data held while stalled
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
        end
        else
        begin
            if (src_valid && src_ch.ready)
            begin
                decode_char(source_chars.pop_front());
                accepted_count++;
            end
            if (!src_valid || src_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    src_valid <= 1'b0;
                end
                else if (source_chars.size() != 0)
                begin
                    src_valid <= 1'b1;
                    src_char  <= source_chars[0].ch;
                    src_last  <= source_chars[0].last;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                                 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    // Sink side: check each item, stall on an 8-bit pattern reloaded at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            dst_ready <= 1'b0;
        end
        else
        begin
            if (dst_ch.valid && dst_ready)
            begin
                if (pending_bytes.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected item byte=%02h last=%0b",
                                            dst_ch.out_byte, dst_ch.out_last));
                end
                else
                begin
                    want = pending_bytes.pop_front();
                    if (dst_ch.out_byte !== want.out_byte)
                    begin
                        flag_mismatch($sformatf("out_byte %02h, expected %02h",
                                                dst_ch.out_byte, want.out_byte));
                    end
                    if (dst_ch.out_last !== want.out_last)
                    begin
                        flag_mismatch($sformatf("out_last %0b, expected %0b",
                                                dst_ch.out_last, want.out_last));
                    end
                    if (want.out_last)
                    begin
                        string_count++;
                    end
                    checked_count++;
                end
            end
            // at least one ready bit per pattern, some patterns never stall
            if (stall_step == 3'd0)
            begin
                stall_bits = ($urandom_range(0, 3) == 0) ? 8'hFF
                                                         : (8'($urandom_range(0, 255)) | 8'h01);
            end
            dst_ready <= stall_bits[stall_step];
            stall_step++;
        end
    end

    // Timeout
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d items still expected",
                 cycle_count, pending_bytes.size());
        $display("Some tests failed");
        $finish;
    end

    // Stimulus build, reset and end of run
    initial
    begin : main_seq
        int         str_len;
        int         kind;
        logic [7:0] c;

        foreach (DIRECTED_ROWS[i])
        begin
            source_chars.push_back(DIRECTED_ROWS[i]);
        end

        // Random strings: mostly well-formed escapes and text, some noise
        while (source_chars.size() < DIRECTED_COUNT + RANDOM_ITEMS)
        begin
            str_len = $urandom_range(1, 16);
            for (int k = 0; k < str_len; k++)
            begin
                kind = $urandom_range(0, 9);
                if (kind <= 3)
                begin
                    do
                    begin
                        c = 8'($urandom_range(0, 255));
                    end
                    while (c == ufd_pkg::CHAR_PERCENT);
                    queue_char(c);
                end
                else if (kind == 4)
                begin
                    queue_char(ufd_pkg::CHAR_PLUS);
                end
                else if (kind <= 7)
                begin
                    queue_char(ufd_pkg::CHAR_PERCENT);
                    queue_char(hex_char());
                    queue_char(hex_char());
                end
                else if (kind == 8)
                begin
                    queue_char(ufd_pkg::CHAR_PERCENT);
                    queue_char(8'($urandom_range(0, 255)));
                    queue_char(8'($urandom_range(0, 255)));
                end
                else
                begin
                    queue_char(8'($urandom_range(0, 255)));
                end
            end
            // now and then end on a cut-off escape
            kind = $urandom_range(0, 7);
            if (kind == 0)
            begin
                queue_char(ufd_pkg::CHAR_PERCENT);
            end
            else if (kind == 1)
            begin
                queue_char(ufd_pkg::CHAR_PERCENT);
                queue_char(hex_char());
            end
            source_chars[source_chars.size() - 1].last = 1'b1;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (source_chars.size() != 0 || pending_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Fed %0d source characters (%0d from the directed table), %0d strings.",
                 accepted_count, DIRECTED_COUNT, string_count);
        $display("Compared %0d decoded items under bursty input and sink stalls.",
                 checked_count);
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
